/* hdl/rtgr_pkg.sv */
package rtgr_pkg;

   localparam int GLYPH_ROWS = 8;
   localparam int GLYPH_COUNT = 26;
   localparam int ADDR_W = 16;
   localparam int BEAT_W = 4;
   localparam logic [BEAT_W-1:0] LAST_BEAT = 4'd15;

   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CASE_FOLD = 8'h20;
   localparam logic [1:0] WHITE_PAIR = 2'b11;
   localparam logic [1:0] BLACK_PAIR = 2'b00;

   typedef struct packed {
      logic [4:0] glyph;
      logic [ADDR_W-1:0] base;
   } glyph_job_type;

   typedef struct packed {
      logic [ADDR_W-1:0] byte_address;
      logic [7:0] byte_data;
      logic last;
   } byte_write_type;

   localparam logic [7:0] FONT_ROM [0:GLYPH_COUNT*GLYPH_ROWS-1] = '{
      8'h1F, 8'h28, 8'h48, 8'h88, 8'h48, 8'h28, 8'h1F, 8'h00,
      8'hFF, 8'h91, 8'h91, 8'h91, 8'h91, 8'h52, 8'h2C, 8'h00,
      8'h7E, 8'h81, 8'h81, 8'h81, 8'h81, 8'h81, 8'h42, 8'h00,
      8'hFF, 8'h81, 8'h81, 8'h81, 8'h81, 8'h42, 8'h3C, 8'h00,
      8'hFF, 8'h91, 8'h91, 8'h91, 8'h91, 8'h81, 8'h81, 8'h00,
      8'hFF, 8'h90, 8'h90, 8'h90, 8'h90, 8'h80, 8'h80, 8'h00,
      8'h7E, 8'h81, 8'h81, 8'h81, 8'h91, 8'h91, 8'h9E, 8'h00,
      8'hFF, 8'h10, 8'h10, 8'h10, 8'h10, 8'h10, 8'hFF, 8'h00,
      8'h81, 8'h81, 8'h81, 8'hFF, 8'h81, 8'h81, 8'h81, 8'h00,
      8'h02, 8'h01, 8'h81, 8'h81, 8'hFE, 8'h80, 8'h80, 8'h00,
      8'hFF, 8'h10, 8'h28, 8'h44, 8'h82, 8'h01, 8'h00, 8'h00,
      8'hFF, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h00,
      8'hFF, 8'h80, 8'h60, 8'h18, 8'h60, 8'h80, 8'hFF, 8'h00,
      8'hFF, 8'h60, 8'h30, 8'h18, 8'h0C, 8'h06, 8'hFF, 8'h00,
      8'h7E, 8'h81, 8'h81, 8'h81, 8'h81, 8'h81, 8'h7E, 8'h00,
      8'hFF, 8'h88, 8'h88, 8'h88, 8'h88, 8'h88, 8'h70, 8'h00,
      8'h7E, 8'h81, 8'h85, 8'h83, 8'h81, 8'h81, 8'h7E, 8'h00,
      8'hFF, 8'h88, 8'h88, 8'h88, 8'h88, 8'h94, 8'hE3, 8'h00,
      8'h66, 8'h91, 8'h91, 8'h91, 8'h91, 8'h91, 8'h8E, 8'h00,
      8'h80, 8'h80, 8'h80, 8'hFF, 8'h80, 8'h80, 8'h80, 8'h00,
      8'hFE, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'hFE, 8'h00,
      8'hC0, 8'h30, 8'h0E, 8'h01, 8'h0E, 8'h30, 8'hC0, 8'h00,
      8'hFE, 8'h01, 8'h02, 8'h3C, 8'h02, 8'h01, 8'hFE, 8'h00,
      8'h83, 8'h44, 8'h28, 8'h10, 8'h28, 8'h44, 8'h83, 8'h00,
      8'h00, 8'hC0, 8'h30, 8'h0F, 8'h30, 8'hC0, 8'h00, 8'h00,
      8'h83, 8'h87, 8'h8D, 8'h99, 8'hB1, 8'hE1, 8'hC1, 8'h00
   };

   // font bit 0 lands in pixel bits 7:6
   function automatic logic [7:0] expand_nibble(input logic [3:0] nib);
      logic [7:0] pix;
      pix = '0;
      for (int b = 0; b < 4; b++) begin
         pix[7-2*b -: 2] = nib[b] ? BLACK_PAIR : WHITE_PAIR;
      end
      return pix;
   endfunction

endpackage

/* hdl/rotated_text_glyph_renderer.sv */
// channel  | dir | handshake              | payload
// req      | in  | req_tvalid/req_tready  | req_tdata: char_code, char_slot, message_length
// rsp      | out | rsp_tvalid/rsp_tready  | rsp_tdata: byte_address, byte_data; rsp_tlast
//
// a drawn letter gives sixteen byte writes, one per cycle unless stalled, back to back with
// the next letter; the rate is set by the byte-at-a-time write sequencer in the back end.
// skipped chars (non-letters, slot >= clamped length) are dropped, yet stall on a full queue.
// a two-entry job queue lets the request side run ahead while the writer is stalled.
// reset is synchronous, active high, and empties the queue and the writer.
module rotated_text_glyph_renderer #(
   parameter int PANEL_WIDTH = 280,
   parameter int PANEL_HEIGHT = 480
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [23:0] req_tdata,  // [7:0] char_code, [15:8] char_slot, [23:16] message_length
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [23:0] rsp_tdata,  // [15:0] byte_address, [23:16] byte_data
   output logic rsp_tlast
);

   logic draw;
   rtgr_pkg::glyph_job_type front_job;
   logic push_ready;
   logic job_valid;
   logic job_ready;
   rtgr_pkg::glyph_job_type queued_job;
   rtgr_pkg::byte_write_type out_write;

   rtgr_front #(
      .PANEL_WIDTH(PANEL_WIDTH),
      .PANEL_HEIGHT(PANEL_HEIGHT)
   ) u_front (
      .char_code(req_tdata[7:0]),
      .char_slot(req_tdata[15:8]),
      .message_length(req_tdata[23:16]),
      .draw(draw),
      .job(front_job)
   );

   // items that draw nothing are accepted and dropped here
   assign req_tready = push_ready;

   rtgr_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push_valid(req_tvalid && draw),
      .push_ready(push_ready),
      .push_job(front_job),
      .pop_valid(job_valid),
      .pop_ready(job_ready),
      .pop_job(queued_job)
   );

   rtgr_back #(
      .PANEL_WIDTH(PANEL_WIDTH)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .job_valid(job_valid),
      .job_ready(job_ready),
      .job(queued_job),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_write(out_write)
   );

   assign rsp_tdata = {out_write.byte_data, out_write.byte_address};
   assign rsp_tlast = out_write.last;

endmodule

/* hdl/rtgr_front.sv */
module rtgr_front #(
   parameter int PANEL_WIDTH = 280,
   parameter int PANEL_HEIGHT = 480
) (
   input  logic [7:0] char_code,
   input  logic [7:0] char_slot,
   input  logic [7:0] message_length,
   output logic draw,
   output rtgr_pkg::glyph_job_type job
);

   localparam int LINE_Y = (PANEL_WIDTH - rtgr_pkg::GLYPH_ROWS) / 2;
   localparam int COLUMN = (PANEL_WIDTH - LINE_Y - 1) / 4;
   localparam int STRIDE = PANEL_WIDTH / 4;
   localparam int MAX_LEN = PANEL_HEIGHT / rtgr_pkg::GLYPH_ROWS;
   localparam int XW = $clog2(PANEL_HEIGHT + 1);

   logic [8:0] len_clamped;
   logic is_lower;
   logic is_upper;
   logic [7:0] upper_code;
   logic [XW-1:0] margin;
   logic [XW-1:0] pos_x;

   always_comb begin
      if ({1'b0, message_length} > 9'(MAX_LEN)) begin
         len_clamped = 9'(MAX_LEN);
      end else begin
         len_clamped = {1'b0, message_length};
      end
   end

   assign is_lower = (char_code >= rtgr_pkg::CHAR_LOWER_A) &&
                     (char_code <= rtgr_pkg::CHAR_LOWER_Z);
   assign is_upper = (char_code >= rtgr_pkg::CHAR_UPPER_A) &&
                     (char_code <= rtgr_pkg::CHAR_UPPER_Z);
   assign upper_code = is_lower ? (char_code - rtgr_pkg::CASE_FOLD) : char_code;

   assign draw = (is_lower || is_upper) && ({1'b0, char_slot} < len_clamped);

   // line is centred vertically, glyphs advance eight rows per slot
   assign margin = XW'(PANEL_HEIGHT) - XW'({len_clamped, 3'b000});
   assign pos_x = (margin >> 1) + XW'({char_slot, 3'b000});

   assign job.glyph = 5'(upper_code - rtgr_pkg::CHAR_UPPER_A);
   assign job.base = rtgr_pkg::ADDR_W'(COLUMN)
                   + rtgr_pkg::ADDR_W'(pos_x) * rtgr_pkg::ADDR_W'(STRIDE);

endmodule

/* hdl/rtgr_queue.sv */
module rtgr_queue (
   input  logic clock,
   input  logic reset,
   input  logic push_valid,
   output logic push_ready,
   input  rtgr_pkg::glyph_job_type push_job,
   output logic pop_valid,
   input  logic pop_ready,
   output rtgr_pkg::glyph_job_type pop_job
);

   rtgr_pkg::glyph_job_type slot_ff [0:1];
   logic wr_ptr_ff, wr_ptr_in;
   logic rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic do_push;
   logic do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_job = slot_ff[rd_ptr_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

/* hdl/rtgr_back.sv */
module rtgr_back #(
   parameter int PANEL_WIDTH = 280
) (
   input  logic clock,
   input  logic reset,
   input  logic job_valid,
   output logic job_ready,
   input  rtgr_pkg::glyph_job_type job,
   output logic out_valid,
   input  logic out_ready,
   output rtgr_pkg::byte_write_type out_write
);

   localparam int STRIDE = PANEL_WIDTH / 4;

   logic active_ff, active_in;
   logic [4:0] glyph_ff, glyph_in;
   logic [rtgr_pkg::ADDR_W-1:0] row_addr_ff, row_addr_in;
   logic [rtgr_pkg::BEAT_W-1:0] beat_ff, beat_in;
   logic out_valid_ff, out_valid_in;
   rtgr_pkg::byte_write_type out_write_ff, out_write_in;
   logic advance;
   logic finishing;
   logic load;
   logic [7:0] font_bits;
   logic [3:0] nibble;

   assign advance = active_ff && (!out_valid_ff || out_ready);
   assign finishing = advance && (beat_ff == rtgr_pkg::LAST_BEAT);
   assign job_ready = !active_ff || finishing;
   assign load = job_valid && job_ready;

   assign font_bits = rtgr_pkg::FONT_ROM[{glyph_ff, beat_ff[3:1]}];
   assign nibble = beat_ff[0] ? font_bits[7:4] : font_bits[3:0];

   always_comb begin
      active_in = active_ff;
      glyph_in = glyph_ff;
      row_addr_in = row_addr_ff;
      beat_in = beat_ff;
      out_valid_in = out_valid_ff && !out_ready;
      out_write_in = out_write_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_write_in.byte_address = row_addr_ff + rtgr_pkg::ADDR_W'(beat_ff[0]);
         out_write_in.byte_data = rtgr_pkg::expand_nibble(nibble);
         out_write_in.last = (beat_ff == rtgr_pkg::LAST_BEAT);
         beat_in = beat_ff + 1'b1;
         // second byte of a row done: step to the next framebuffer line
         if (beat_ff[0]) begin
            row_addr_in = row_addr_ff + rtgr_pkg::ADDR_W'(STRIDE);
         end
      end
      if (finishing) begin
         active_in = 1'b0;
      end
      if (load) begin
         active_in = 1'b1;
         glyph_in = job.glyph;
         row_addr_in = job.base;
         beat_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         beat_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         beat_ff <= beat_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      glyph_ff <= glyph_in;
      row_addr_ff <= row_addr_in;
      out_write_ff <= out_write_in;
   end

   assign out_valid = out_valid_ff;
   assign out_write = out_write_ff;

`ifndef SYNTH
   a_last_on_final_beat: assert property (@(posedge clock) disable iff (reset)
      advance |=> (out_write_ff.last == ($past(beat_ff) == rtgr_pkg::LAST_BEAT)))
      else $error("last flag does not match the beat that produced it");

   a_load_restarts_beat: assert property (@(posedge clock) disable iff (reset)
      load |=> (active_ff && beat_ff == '0))
      else $error("new glyph did not start at beat zero");

   a_idle_beat_zero: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> (beat_ff == '0))
      else $error("beat counter left mid-glyph while idle");

   a_row_holds_on_even_beat: assert property (@(posedge clock) disable iff (reset)
      (advance && !beat_ff[0] && !load) |=> $stable(row_addr_ff))
      else $error("row address moved between the two bytes of a row");
`endif

endmodule

/* dv/glyph_write_checker.sv */
module glyph_write_checker #(
   parameter int PANEL_WIDTH = 280,
   parameter int PANEL_HEIGHT = 480
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   input  logic req_tready,
   input  logic [23:0] req_tdata,  // [7:0] char_code, [15:8] char_slot, [23:16] message_length
   input  logic rsp_tvalid,
   input  logic rsp_tready,
   input  logic [23:0] rsp_tdata,  // [15:0] byte_address, [23:16] byte_data
   input  logic rsp_tlast,
   output int unsigned writes_pending,
   output int unsigned mismatches
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_CHARS = PANEL_HEIGHT / rtgr_pkg::GLYPH_ROWS;
   localparam int LINE_Y = (PANEL_WIDTH - rtgr_pkg::GLYPH_ROWS) / 2;
   localparam int COLUMN = (PANEL_WIDTH - LINE_Y - 1) / 4;
   localparam int ROW_STRIDE = PANEL_WIDTH / 4;

   // one byte per glyph row, font bit 0 is the first pixel of the row
   localparam logic [7:0] GLYPH_BITS [0:26*8-1] = '{
      8'h1F, 8'h28, 8'h48, 8'h88, 8'h48, 8'h28, 8'h1F, 8'h00,
      8'hFF, 8'h91, 8'h91, 8'h91, 8'h91, 8'h52, 8'h2C, 8'h00,
      8'h7E, 8'h81, 8'h81, 8'h81, 8'h81, 8'h81, 8'h42, 8'h00,
      8'hFF, 8'h81, 8'h81, 8'h81, 8'h81, 8'h42, 8'h3C, 8'h00,
      8'hFF, 8'h91, 8'h91, 8'h91, 8'h91, 8'h81, 8'h81, 8'h00,
      8'hFF, 8'h90, 8'h90, 8'h90, 8'h90, 8'h80, 8'h80, 8'h00,
      8'h7E, 8'h81, 8'h81, 8'h81, 8'h91, 8'h91, 8'h9E, 8'h00,
      8'hFF, 8'h10, 8'h10, 8'h10, 8'h10, 8'h10, 8'hFF, 8'h00,
      8'h81, 8'h81, 8'h81, 8'hFF, 8'h81, 8'h81, 8'h81, 8'h00,
      8'h02, 8'h01, 8'h81, 8'h81, 8'hFE, 8'h80, 8'h80, 8'h00,
      8'hFF, 8'h10, 8'h28, 8'h44, 8'h82, 8'h01, 8'h00, 8'h00,
      8'hFF, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h00,
      8'hFF, 8'h80, 8'h60, 8'h18, 8'h60, 8'h80, 8'hFF, 8'h00,
      8'hFF, 8'h60, 8'h30, 8'h18, 8'h0C, 8'h06, 8'hFF, 8'h00,
      8'h7E, 8'h81, 8'h81, 8'h81, 8'h81, 8'h81, 8'h7E, 8'h00,
      8'hFF, 8'h88, 8'h88, 8'h88, 8'h88, 8'h88, 8'h70, 8'h00,
      8'h7E, 8'h81, 8'h85, 8'h83, 8'h81, 8'h81, 8'h7E, 8'h00,
      8'hFF, 8'h88, 8'h88, 8'h88, 8'h88, 8'h94, 8'hE3, 8'h00,
      8'h66, 8'h91, 8'h91, 8'h91, 8'h91, 8'h91, 8'h8E, 8'h00,
      8'h80, 8'h80, 8'h80, 8'hFF, 8'h80, 8'h80, 8'h80, 8'h00,
      8'hFE, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'hFE, 8'h00,
      8'hC0, 8'h30, 8'h0E, 8'h01, 8'h0E, 8'h30, 8'hC0, 8'h00,
      8'hFE, 8'h01, 8'h02, 8'h3C, 8'h02, 8'h01, 8'hFE, 8'h00,
      8'h83, 8'h44, 8'h28, 8'h10, 8'h28, 8'h44, 8'h83, 8'h00,
      8'h00, 8'hC0, 8'h30, 8'h0F, 8'h30, 8'hC0, 8'h00, 8'h00,
      8'h83, 8'h87, 8'h8D, 8'h99, 8'hB1, 8'hE1, 8'hC1, 8'h00
   };

   rtgr_pkg::byte_write_type pending_writes [$];

   // clear font bit paints white, the first bit goes to the top pixel pair
   function automatic logic [7:0] nibble_pixels(input logic [3:0] nib);
      logic [7:0] pix;
      pix = 8'h00;
      for (int b = 0; b < 4; b++) begin
         if (!nib[b]) pix = pix | ({6'b0, rtgr_pkg::WHITE_PAIR} << (6 - 2 * b));
      end
      return pix;
   endfunction

   function automatic void render_glyph(input logic [7:0] code, input logic [7:0] slot,
                                        input logic [7:0] len);
      int clamped;
      int letter;
      int x;
      int address;
      logic [7:0] row_bits;
      rtgr_pkg::byte_write_type w;
      clamped = (len > MAX_CHARS) ? MAX_CHARS : int'(len);
      if (slot >= clamped) return;
      if (code >= rtgr_pkg::CHAR_LOWER_A && code <= rtgr_pkg::CHAR_LOWER_Z) begin
         letter = int'(code) - int'(rtgr_pkg::CHAR_LOWER_A);
      end else if (code >= rtgr_pkg::CHAR_UPPER_A && code <= rtgr_pkg::CHAR_UPPER_Z) begin
         letter = int'(code) - int'(rtgr_pkg::CHAR_UPPER_A);
      end else begin
         return;
      end
      x = (PANEL_HEIGHT - rtgr_pkg::GLYPH_ROWS * clamped) / 2
        + rtgr_pkg::GLYPH_ROWS * int'(slot);
      for (int r = 0; r < rtgr_pkg::GLYPH_ROWS; r++) begin
         row_bits = GLYPH_BITS[letter * rtgr_pkg::GLYPH_ROWS + r];
         for (int k = 0; k < 2; k++) begin
            address = COLUMN + (x + r) * ROW_STRIDE + k;
            w.byte_address = address[rtgr_pkg::ADDR_W-1:0];
            w.byte_data = nibble_pixels(row_bits[4*k +: 4]);
            w.last = (r == rtgr_pkg::GLYPH_ROWS - 1) && (k == 1);
            pending_writes.push_back(w);
         end
      end
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("%0t ns: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
      mismatches++;
   endtask

   task automatic check_write();
      rtgr_pkg::byte_write_type want;
      if (pending_writes.size() == 0) begin
         report_mismatch("unexpected write transaction, address", 32'(rsp_tdata[15:0]), 0);
      end else begin
         want = pending_writes.pop_front();
         if (rsp_tdata[15:0] !== want.byte_address)
            report_mismatch("byte_address", 32'(rsp_tdata[15:0]), 32'(want.byte_address));
         if (rsp_tdata[23:16] !== want.byte_data)
            report_mismatch("byte_data", 32'(rsp_tdata[23:16]), 32'(want.byte_data));
         if (rsp_tlast !== want.last)
            report_mismatch("last", 32'(rsp_tlast), 32'(want.last));
      end
   endtask

   initial mismatches = 0;

   always @(posedge clock) begin
      if (reset) begin
         pending_writes.delete();
      end else begin
         if (req_tvalid && req_tready)
            render_glyph(req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]);
         if (rsp_tvalid && rsp_tready) check_write();
      end
      writes_pending <= pending_writes.size();
   end

endmodule

/* dv/rotated_text_glyph_renderer_test.sv */
module rotated_text_glyph_renderer_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PANEL_WIDTH = 280;
   localparam int PANEL_HEIGHT = 480;
   localparam int MAX_CHARS = PANEL_HEIGHT / rtgr_pkg::GLYPH_ROWS;
   localparam int RANDOM_CHARS = 300;
   localparam int DRAIN_CYCLES = 40;
   localparam int WATCHDOG_LIMIT = 1000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid;
   logic req_tready;
   logic [23:0] req_tdata;  // [7:0] char_code, [15:8] char_slot, [23:16] message_length
   logic rsp_tvalid;
   logic rsp_tready;
   logic [23:0] rsp_tdata;  // [15:0] byte_address, [23:16] byte_data
   logic rsp_tlast;
   int unsigned writes_pending;
   int unsigned mismatches;
   bit sender_steady = 1'b0;

   rotated_text_glyph_renderer #(
      .PANEL_WIDTH(PANEL_WIDTH),
      .PANEL_HEIGHT(PANEL_HEIGHT)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   glyph_write_checker #(
      .PANEL_WIDTH(PANEL_WIDTH),
      .PANEL_HEIGHT(PANEL_HEIGHT)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .writes_pending(writes_pending),
      .mismatches(mismatches)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   // keeps valid high across back-to-back transactions
   task automatic send_char(input logic [7:0] code, input logic [7:0] slot,
                            input logic [7:0] len);
      int unsigned gap;
      gap = sender_steady ? 0 : $urandom_range(0, 14);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {len, slot, code};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   initial begin
      logic [23:0] directed_chars [0:19];
      logic [7:0] code;
      logic [7:0] slot;
      logic [7:0] len;
      int clamped;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      directed_chars = '{
         {8'd1, 8'd0, "A"},      // single character message
         {8'd60, 8'd0, "Z"},     // full line, lowest address
         {8'd60, 8'd59, "z"},    // full line, highest address
         {8'd255, 8'd59, "a"},   // length clamped
         {8'd255, 8'd60, "M"},   // slot at the clamped length
         {8'd255, 8'd255, "Q"},
         {8'd0, 8'd0, "B"},      // empty message
         {8'd3, 8'd3, "C"},
         {8'd3, 8'd2, "c"},
         {8'd5, 8'd1, "@"},      // just outside the letter ranges
         {8'd5, 8'd1, "["},
         {8'd5, 8'd1, 8'h60},
         {8'd5, 8'd1, "{"},
         {8'd5, 8'd1, 8'h00},
         {8'd5, 8'd1, 8'hFF},
         {8'd5, 8'd1, 8'hC1},    // letter code with the top bit set
         {8'd5, 8'd1, 8'hE1},
         {8'd61, 8'd7, "W"},
         {8'd2, 8'd1, "X"},
         {8'd128, 8'd0, "y"}
      };
      while (reset) @(posedge clock);

      foreach (directed_chars[i])
         send_char(directed_chars[i][7:0], directed_chars[i][15:8], directed_chars[i][23:16]);

      // let the block drain completely before the random part
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (writes_pending != 0) @(posedge clock);

      for (int i = 0; i < RANDOM_CHARS; i++) begin
         if (i % 50 == 0) sender_steady = ($urandom_range(0, 2) == 0);
         if ($urandom_range(0, 9) < 7) begin
            len = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(MAX_CHARS + 1, 255))
                                              : 8'($urandom_range(1, MAX_CHARS));
            clamped = (len > MAX_CHARS) ? MAX_CHARS : int'(len);
            slot = 8'($urandom_range(0, clamped - 1));
            code = 8'(($urandom_range(0, 1) ? rtgr_pkg::CHAR_UPPER_A
                                            : rtgr_pkg::CHAR_LOWER_A)
                      + $urandom_range(0, 25));
         end else begin
            code = 8'($urandom);
            slot = 8'($urandom);
            len = 8'($urandom);
         end
         send_char(code, slot, len);
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (writes_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      int unsigned stall;
      int unsigned taken;
      bit steady;
      rsp_tready <= 1'b0;
      taken = 0;
      steady = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (taken % 64 == 0) steady = ($urandom_range(0, 3) == 0);
         taken++;
         stall = steady ? 0 : $urandom_range(0, 14);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // ends a hung run: no transaction on either channel for too long
   initial begin
      int unsigned quiet;
      quiet = 0;
      while (reset) @(posedge clock);
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
